FILE: hdl/oal_pkg.sv
package oal_pkg;

	// Request codes
	localparam logic [2:0] REQ_CLEAR     = 3'd0;
	localparam logic [2:0] REQ_INSERT    = 3'd1;
	localparam logic [2:0] REQ_DELETE    = 3'd2;
	localparam logic [2:0] REQ_READ      = 3'd3;
	localparam logic [2:0] REQ_OVERWRITE = 3'd4;
	localparam logic [2:0] REQ_FIND      = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned DATA_W = 64;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [4:0]        position;
		logic              append;
		logic [KEY_W-1:0]  title_key;
		logic [DATA_W-1:0] payload;
	} oal_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [4:0]        found_position;
		logic [KEY_W-1:0]  key_out;
		logic [DATA_W-1:0] data_out;
		logic [5:0]        entry_count;
	} oal_rsp_t;

	// One stored list entry
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} oal_entry_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_CAP,
		S_DEL_LOOP,
		S_DEL_WR,
		S_RD_ISSUE,
		S_RD_CAP,
		S_OVW,
		S_FIND_RD,
		S_FIND_CMP,
		S_FINISH
	} oal_state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_COUNT,
		IDX_POS,
		IDX_INC,
		IDX_DEC
	} oal_idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_PREV,
		RD_NEXT
	} oal_rd_sel_t;

	typedef enum logic [1:0] {
		RES_HOLD,
		RES_ZERO,
		RES_REQ,
		RES_MEM
	} oal_res_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLEAR,
		CNT_INC,
		CNT_DEC
	} oal_cnt_op_t;

	// Sequencer to datapath
	typedef struct packed {
		logic        capture;
		oal_idx_op_t idx_op;
		logic        rd_en;
		oal_rd_sel_t rd_sel;
		logic        wr_en;
		logic        wr_req;
		oal_res_op_t res_op;
		logic [1:0]  res_status;
		oal_cnt_op_t cnt_op;
		logic        res_load;
	} oal_cmd_t;

	// Datapath to sequencer
	typedef struct packed {
		logic [2:0] req_type;
		logic       full;
		logic       pos_bad;
		logic       ins_bad;
		logic       idx_gt_tgt;
		logic       idx_lt_cnt;
		logic       idx_nxt_lt_cnt;
		logic       key_match;
		logic       out_free;
	} oal_status_t;

endpackage

FILE: hdl/ordered_array_list_engine.sv
// Channel   Handshake              Payload    Moves
// req       req_valid / req_stall  req_data   one request into the engine
// res       res_valid / res_stall  res_data   one result per request
//
// Requests are taken one at a time; the next is taken while a result waits.
// n = entries, p = slot: insert shifts entries p..n-1 up, delete shifts entries
// p+1..n-1 down, find scans from slot 0 to a hit or to n; clear, error,
// read and overwrite touch no other slot. Shifts and compares go one entry at a time
// through the store. A stalled earlier result holds the engine in its finish state.
// arst_n empties the list; the store itself is not cleared.
module ordered_array_list_engine #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  oal_pkg::oal_req_t req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output oal_pkg::oal_rsp_t res_data
);
	import oal_pkg::*;

	oal_cmd_t    cmd;
	oal_status_t status;

	oal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	oal_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

FILE: hdl/oal_ctrl.sv
module oal_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  oal_pkg::oal_status_t status,
	output oal_pkg::oal_cmd_t    cmd
);
	import oal_pkg::*;

	oal_state_t state_q;
	oal_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.req_type)
					REQ_INSERT: begin
						if (status.full || status.ins_bad) begin
							state_d = S_FINISH;
						end else begin
							state_d = S_INS_RD;
						end
					end
					REQ_DELETE: begin
						state_d = status.pos_bad ? S_FINISH : S_DEL_RD;
					end
					REQ_READ: begin
						state_d = status.pos_bad ? S_FINISH : S_RD_ISSUE;
					end
					REQ_OVERWRITE: begin
						state_d = status.pos_bad ? S_FINISH : S_OVW;
					end
					REQ_FIND: begin
						state_d = S_FIND_RD;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_INS_RD: begin
				state_d = status.idx_gt_tgt ? S_INS_WR : S_FINISH;
			end
			S_INS_WR:   state_d = S_INS_RD;
			S_DEL_RD:   state_d = S_DEL_CAP;
			S_DEL_CAP:  state_d = S_DEL_LOOP;
			S_DEL_LOOP: begin
				state_d = status.idx_nxt_lt_cnt ? S_DEL_WR : S_FINISH;
			end
			S_DEL_WR:   state_d = S_DEL_LOOP;
			S_RD_ISSUE: state_d = S_RD_CAP;
			S_RD_CAP:   state_d = S_FINISH;
			S_OVW:      state_d = S_FINISH;
			S_FIND_RD: begin
				state_d = status.idx_lt_cnt ? S_FIND_CMP : S_FINISH;
			end
			S_FIND_CMP: begin
				state_d = status.key_match ? S_FINISH : S_FIND_RD;
			end
			S_FINISH: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
			end
			S_DECODE: begin
				unique case (status.req_type)
					REQ_CLEAR: begin
						cmd.res_op     = RES_ZERO;
						cmd.res_status = ST_OK;
						cmd.cnt_op     = CNT_CLEAR;
					end
					REQ_INSERT: begin
						priority if (status.full) begin
							cmd.res_op     = RES_ZERO;
							cmd.res_status = ST_FULL;
						end else if (status.ins_bad) begin
							cmd.res_op     = RES_ZERO;
							cmd.res_status = ST_BAD;
						end else begin
							cmd.idx_op = IDX_COUNT;
						end
					end
					REQ_DELETE, REQ_READ, REQ_OVERWRITE: begin
						if (status.pos_bad) begin
							cmd.res_op     = RES_ZERO;
							cmd.res_status = ST_BAD;
						end else begin
							cmd.idx_op = IDX_POS;
						end
					end
					REQ_FIND: begin
						cmd.idx_op = IDX_ZERO;
					end
					default: begin
						cmd.res_op     = RES_ZERO;
						cmd.res_status = ST_BAD;
					end
				endcase
			end
			// move entry idx-1 up, or drop the new entry in at idx
			S_INS_RD: begin
				if (status.idx_gt_tgt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_req = 1'b1;
					cmd.res_op = RES_REQ;
					cmd.cnt_op = CNT_INC;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = IDX_DEC;
			end
			S_DEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
			end
			S_DEL_CAP: begin
				cmd.res_op = RES_MEM;
			end
			// pull entry idx+1 down until the tail is reached
			S_DEL_LOOP: begin
				if (status.idx_nxt_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end else begin
					cmd.cnt_op = CNT_DEC;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = IDX_INC;
			end
			S_RD_ISSUE: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
			end
			S_RD_CAP: begin
				cmd.res_op = RES_MEM;
			end
			S_OVW: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_req = 1'b1;
				cmd.res_op = RES_REQ;
			end
			// linear scan, one entry at a time
			S_FIND_RD: begin
				if (status.idx_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
				end else begin
					cmd.res_op     = RES_ZERO;
					cmd.res_status = ST_MISS;
				end
			end
			S_FIND_CMP: begin
				if (status.key_match) begin
					cmd.res_op = RES_MEM;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_FINISH: begin
				cmd.res_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hdl/oal_dp.sv
module oal_dp #(
	parameter int CAPACITY = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oal_pkg::oal_req_t    req_data,
	input  oal_pkg::oal_cmd_t    cmd,
	output oal_pkg::oal_status_t status,
	output logic                 res_valid,
	input  logic                 res_stall,
	output oal_pkg::oal_rsp_t    res_data
);
	import oal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	oal_req_t   req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	oal_entry_t mem [CAPACITY];
	oal_entry_t rdata_q;
	oal_rsp_t   res_q;
	oal_rsp_t   out_q;
	logic       out_valid_q;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [AW-1:0] rd_addr;
	oal_entry_t    wr_entry;
	logic [XW-1:0] count_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] tgt_x;
	logic [XW:0]   idx_nxt_x;
	logic [4:0]    slot;
	logic          out_free;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	// Widened views for compares
	assign count_x   = XW'(count_q);
	assign pos_x     = XW'(req_q.position);
	assign idx_x     = XW'(idx_q);
	assign tgt_x     = req_q.append ? count_x : pos_x;
	assign idx_nxt_x = {1'b0, idx_x} + (XW + 1)'(1);
	assign slot      = idx_x[4:0];
	assign out_free  = !out_valid_q || !res_stall;

	always_comb begin
		status.req_type       = req_q.req_type;
		status.full           = (count_x >= XW'(CAPACITY));
		status.pos_bad        = (pos_x >= count_x);
		status.ins_bad        = !req_q.append && (pos_x > count_x);
		status.idx_gt_tgt     = (idx_x > tgt_x);
		status.idx_lt_cnt     = (idx_x < count_x);
		status.idx_nxt_lt_cnt = (idx_nxt_x < {1'b0, count_x});
		status.key_match      = (rdata_q.key == req_q.title_key);
		status.out_free       = out_free;
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_CLEAR: count_q <= '0;
				CNT_INC:   count_q <= count_q + CW'(1);
				CNT_DEC:   count_q <= count_q - CW'(1);
				default:   count_q <= count_q;
			endcase
		end
	end

	// Slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			unique case (cmd.idx_op)
				IDX_ZERO:  idx_q <= '0;
				IDX_COUNT: idx_q <= count_q;
				IDX_POS:   idx_q <= CW'(req_q.position);
				IDX_INC:   idx_q <= idx_p1;
				IDX_DEC:   idx_q <= idx_m1;
				default:   idx_q <= idx_q;
			endcase
		end
	end

	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PREV: rd_addr = idx_m1[AW-1:0];
			RD_NEXT: rd_addr = idx_p1[AW-1:0];
			default: rd_addr = idx_q[AW-1:0];
		endcase
	end

	// New entry from the request, or the entry read for a shift
	always_comb begin
		if (cmd.wr_req) begin
			wr_entry.key  = req_q.title_key;
			wr_entry.data = req_q.payload;
		end else begin
			wr_entry = rdata_q;
		end
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[idx_q[AW-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Result staging; count is filled in on load
	always_ff @(posedge clk) begin
		unique case (cmd.res_op)
			RES_ZERO: begin
				res_q.status         <= cmd.res_status;
				res_q.found_position <= '0;
				res_q.key_out        <= '0;
				res_q.data_out       <= '0;
			end
			RES_REQ: begin
				res_q.status         <= ST_OK;
				res_q.found_position <= slot;
				res_q.key_out        <= req_q.title_key;
				res_q.data_out       <= req_q.payload;
			end
			RES_MEM: begin
				res_q.status         <= ST_OK;
				res_q.found_position <= slot;
				res_q.key_out        <= rdata_q.key;
				res_q.data_out       <= rdata_q.data;
			end
			default: begin
				res_q.status         <= res_q.status;
				res_q.found_position <= res_q.found_position;
				res_q.key_out        <= res_q.key_out;
				res_q.data_out       <= res_q.data_out;
			end
		endcase
		res_q.entry_count <= '0;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status         <= res_q.status;
			out_q.found_position <= res_q.found_position;
			out_q.key_out        <= res_q.key_out;
			out_q.data_out       <= res_q.data_out;
			out_q.entry_count    <= count_x[5:0] | res_q.entry_count;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_x <= XW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == CW'($past(count_q) + CW'(1)) ||
			count_q == CW'($past(count_q) - CW'(1)) || count_q == '0))
		else $error("entry count moved by more than one");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("store read and written in the same cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded over one not yet taken");

endmodule
